// ===== hdl/arpv_pkg.sv =====
// Shared constants, types and table builders for the rotate and project vertex unit.
`timescale 1ns / 1ps
`default_nettype none

package arpv_pkg;

    // Fixed-point format and table length
    localparam int FRAC        = 16;
    localparam int ONE_FX      = 1 << FRAC;
    localparam int TABLE_STEPS = 128;
    localparam int IDXW        = $clog2(TABLE_STEPS);

    // Field widths
    localparam int ANGW  = 7;
    localparam int AXW   = 18;
    localparam int VW    = 24;
    localparam int FOVW  = 24;
    localparam int CAMW  = 24;
    localparam int VOFFW = 10;
    localparam int SW    = 16;

    // Configuration port
    localparam int CFG_IDXW = 3;
    localparam int CFG_DW   = 24;
    localparam logic [CFG_IDXW-1:0] CFG_ANGLE = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_AXIS_X = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_AXIS_Y = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_AXIS_Z = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_FOCAL = 3'd4;
    localparam logic [CFG_IDXW-1:0] CFG_CAMDIST = 3'd5;
    localparam logic [CFG_IDXW-1:0] CFG_VOFF = 3'd6;

    // Register reset values
    localparam logic signed [AXW-1:0] RST_AXIS_X = 18'sd43647;
    localparam logic signed [AXW-1:0] RST_AXIS_Y = 18'sd43647;
    localparam logic signed [AXW-1:0] RST_AXIS_Z = 18'sd21823;
    localparam logic [FOVW-1:0]       RST_FOCAL  = 24'd131072;
    localparam logic [CAMW-1:0]       RST_CAMD   = 24'd327680;

    // Matrix build widths
    localparam int ROMW  = 18;
    localparam int MCW   = 19;
    localparam int PW    = 20;
    localparam int DXW   = 21;
    localparam int LW    = 24;
    localparam int MW    = 34;
    localparam int MAT_N = 9;
    localparam int LOW   = 17;
    localparam int HIW   = MW - LOW;
    localparam int VIEW_SCALE = 240;

    // Transform and divide widths
    localparam int CW     = 44;
    localparam int DENW   = CW;
    localparam int HALFW  = CW / 2;
    localparam int NW     = CW + FOVW - FRAC;
    localparam int QBITS  = 17;
    localparam int DIV_LAT = QBITS + 1;
    localparam int CENTER_X = 320;
    localparam int CENTER_Y = 240;

    typedef struct packed {
        logic [ANGW-1:0]        angle;
        logic signed [AXW-1:0]  ax;
        logic signed [AXW-1:0]  ay;
        logic signed [AXW-1:0]  az;
    } t_rot_cfg;

    typedef logic signed [MW-1:0] t_mat [MAT_N];
    typedef logic signed [ROMW-1:0] t_rom [TABLE_STEPS];

    // Series constants in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

    // Round half up to FRAC fraction bits (floor of value plus half)
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // Clamp a Q30 value to [0,1] and round to FRAC bits
    function automatic logic signed [63:0] f_q30_to_fx(input logic signed [63:0] v);
        logic signed [63:0] vc;
        vc = v;
        if (vc < 0) vc = 0;
        if (vc > $signed(Q30_ONE)) vc = $signed(Q30_ONE);
        return (vc + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // Sine or cosine table: quadrant fold plus Taylor series, built at elaboration
    function automatic t_rom f_build_rom(input logic sel_sine);
        t_rom rom;
        logic [63:0] p, r, x, x2, ts, tc;
        logic signed [63:0] ss, cs, s, c, sv, cv;
        logic [1:0] q;
        for (int i = 0; i < TABLE_STEPS; i++) begin
            p  = (64'(i) << 32) / TABLE_STEPS;
            q  = p[31:30];
            r  = p & 64'h3FFF_FFFF;
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            ts = x;
            tc = Q30_ONE;
            ss = $signed(x);
            cs = $signed(Q30_ONE);
            for (int k = 0; k < 7; k++) begin
                ts = ((ts * x2) >> 30) / SIN_DIV[k];
                tc = ((tc * x2) >> 30) / COS_DIV[k];
                if ((k & 1) != 0) begin
                    ss = ss + $signed(ts);
                    cs = cs + $signed(tc);
                end else begin
                    ss = ss - $signed(ts);
                    cs = cs - $signed(tc);
                end
            end
            s = f_q30_to_fx(ss);
            c = f_q30_to_fx(cs);
            case (q)
                2'd0: begin sv = s;  cv = c;  end
                2'd1: begin sv = c;  cv = -s; end
                2'd2: begin sv = -s; cv = -c; end
                default: begin sv = -c; cv = s; end
            endcase
            rom[i] = sel_sine ? ROMW'(sv) : ROMW'(cv);
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = f_build_rom(1'b1);
    localparam t_rom COS_ROM = f_build_rom(1'b0);

endpackage

`default_nettype wire

// ===== hdl/arpv_matrix.sv =====
// Three-stage rebuild of the scaled Rodrigues rotation matrix from axis and angle.
`timescale 1ns / 1ps
`default_nettype none

module arpv_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  arpv_pkg::t_rot_cfg i_cfg,
    output arpv_pkg::t_mat     o_mat,
    output logic               o_busy
);
    import arpv_pkg::*;

    localparam logic [1:0] BUILD_STEPS = 2'd3;
    localparam logic signed [MCW-1:0] ONE_MC = MCW'(ONE_FX);
    localparam logic signed [DXW-1:0] ONE_DX = DXW'(ONE_FX);
    localparam logic signed [MW-1:0]  ONE_M  = MW'(ONE_FX);
    localparam logic signed [MW-1:0]  VS     = MW'(VIEW_SCALE);

    logic [1:0] r_cnt;

    logic signed [MCW-1:0]  r_mc;
    logic signed [ROMW-1:0] r_ms;
    logic signed [PW-1:0]   r_pxx, r_pyy, r_pzz, r_pyz, r_pzx, r_pxy;
    logic signed [LW-1:0]   r_lx, r_ly, r_lz, r_cx, r_cy, r_cz, r_sx, r_sy, r_sz;
    t_mat r_mat;

    logic signed [2*AXW-1:0] w_axx, w_ayy, w_azz, w_ayz, w_azx, w_axy;
    logic signed [DXW-1:0]   w_dx, w_dy, w_dz;
    logic signed [DXW+MCW-1:0] w_lx, w_ly, w_lz;
    logic signed [PW+MCW-1:0]  w_cx, w_cy, w_cz;
    logic signed [AXW+ROMW-1:0] w_sx, w_sy, w_sz;
    logic signed [MW-1:0] w_tx, w_ty, w_tz;

    // stage 1: axis products
    always_comb begin
        w_axx = i_cfg.ax * i_cfg.ax;
        w_ayy = i_cfg.ay * i_cfg.ay;
        w_azz = i_cfg.az * i_cfg.az;
        w_ayz = i_cfg.ay * i_cfg.az;
        w_azx = i_cfg.az * i_cfg.ax;
        w_axy = i_cfg.ax * i_cfg.ay;
    end

    // stage 2: products with 1-cos and sin
    always_comb begin
        w_dx = ONE_DX - DXW'(r_pxx);
        w_dy = ONE_DX - DXW'(r_pyy);
        w_dz = ONE_DX - DXW'(r_pzz);
        w_lx = w_dx * r_mc;
        w_ly = w_dy * r_mc;
        w_lz = w_dz * r_mc;
        w_cx = r_pyz * r_mc;
        w_cy = r_pzx * r_mc;
        w_cz = r_pxy * r_mc;
        w_sx = i_cfg.ax * r_ms;
        w_sy = i_cfg.ay * r_ms;
        w_sz = i_cfg.az * r_ms;
    end

    // stage 3: diagonal terms
    always_comb begin
        w_tx = ONE_M - MW'(r_lx);
        w_ty = ONE_M - MW'(r_ly);
        w_tz = ONE_M - MW'(r_lz);
    end

    // free-running build pipeline; values only change after a register write
    always_ff @(posedge i_clk) begin
        r_mc  <= ONE_MC - MCW'(COS_ROM[i_cfg.angle[IDXW-1:0]]);
        r_ms  <= SIN_ROM[i_cfg.angle[IDXW-1:0]];
        r_pxx <= PW'(f_rnd(64'(w_axx)));
        r_pyy <= PW'(f_rnd(64'(w_ayy)));
        r_pzz <= PW'(f_rnd(64'(w_azz)));
        r_pyz <= PW'(f_rnd(64'(w_ayz)));
        r_pzx <= PW'(f_rnd(64'(w_azx)));
        r_pxy <= PW'(f_rnd(64'(w_axy)));

        r_lx <= LW'(f_rnd(64'(w_lx)));
        r_ly <= LW'(f_rnd(64'(w_ly)));
        r_lz <= LW'(f_rnd(64'(w_lz)));
        r_cx <= LW'(f_rnd(64'(w_cx)));
        r_cy <= LW'(f_rnd(64'(w_cy)));
        r_cz <= LW'(f_rnd(64'(w_cz)));
        r_sx <= LW'(f_rnd(64'(w_sx)));
        r_sy <= LW'(f_rnd(64'(w_sy)));
        r_sz <= LW'(f_rnd(64'(w_sz)));

        r_mat[0] <= MW'(w_tx * VS);
        r_mat[1] <= MW'((MW'(r_cz) + MW'(r_sz)) * VS);
        r_mat[2] <= MW'(r_cy) - MW'(r_sy);
        r_mat[3] <= MW'((MW'(r_cz) - MW'(r_sz)) * VS);
        r_mat[4] <= MW'(w_ty * VS);
        r_mat[5] <= MW'(r_cx) + MW'(r_sx);
        r_mat[6] <= MW'((MW'(r_cy) + MW'(r_sy)) * VS);
        r_mat[7] <= MW'((MW'(r_cx) - MW'(r_sx)) * VS);
        r_mat[8] <= w_tz;
    end

    // busy count covers the three build stages after reset or a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= BUILD_STEPS;
        end else if (i_start) begin
            r_cnt <= BUILD_STEPS;
        end else if (r_cnt != 2'd0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    assign o_busy = (r_cnt != 2'd0);
    assign o_mat  = r_mat;

endmodule

`default_nettype wire

// ===== hdl/arpv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage with overflow detect.
`timescale 1ns / 1ps
`default_nettype none

module arpv_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [arpv_pkg::NW-1:0]     i_num,
    input  logic [arpv_pkg::DENW-1:0]   i_den,
    output logic [arpv_pkg::QBITS-1:0]  o_quo,
    output logic                        o_ovf
);
    import arpv_pkg::*;

    localparam int CMPW = DENW + QBITS + 1;

    logic [NW-1:0]    r_rem [DIV_LAT];
    logic [QBITS-1:0] r_quo [DIV_LAT];
    logic             r_ovf [DIV_LAT];
    logic [DENW-1:0]  r_dv  [DIV_LAT-1];

    logic [NW-1:0]    n_rem   [DIV_LAT];
    logic [QBITS-1:0] n_quo   [DIV_LAT];
    logic [CMPW-1:0]  n_trial [DIV_LAT];

    // trial subtract per stage, most significant quotient bit first
    always_comb begin
        n_rem[0]   = i_num;
        n_quo[0]   = '0;
        n_trial[0] = CMPW'(i_den) << QBITS;
        for (int k = 1; k < DIV_LAT; k++) begin
            n_trial[k] = CMPW'(r_dv[k-1]) << (QBITS - k);
            n_rem[k]   = r_rem[k-1];
            n_quo[k]   = r_quo[k-1];
            if (CMPW'(r_rem[k-1]) >= n_trial[k]) begin
                n_rem[k] = NW'(CMPW'(r_rem[k-1]) - n_trial[k]);
                n_quo[k][QBITS-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_quo[0] <= n_quo[0];
            r_dv[0]  <= i_den;
            r_ovf[0] <= (CMPW'(i_num) >= n_trial[0]);
            for (int k = 1; k < DIV_LAT; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= r_ovf[k-1];
            end
            for (int k = 1; k < DIV_LAT - 1; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule

`default_nettype wire

// ===== hdl/axis_rotate_project_vertex_unit.sv =====
// Top level: vertex rotation by an axis-angle matrix and perspective projection.
//
// Input channel i_valid/o_ready carries one vertex word (Q8.16 x, y, z and a
// last flag); output channel o_valid/i_ready carries one screen word per vertex
// (saturated 16-bit x and y, depth fault, last flag), in input order.
// Throughput: one vertex per clock while the pipeline is not stalled and no
// matrix rebuild holds o_ready low. Stages: 7 transform stages (matrix multiply,
// sum, depth, projection numerator), then 18 stages of the divider, one quotient
// bit per stage after the first, and the output register.
// The whole pipeline advances when the output register is empty or taken, so
// a stalled receiver freezes every stage and nothing is lost or repeated.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at once;
// any write, and reset, starts a matrix rebuild during which o_ready
// is low. Indexes past the register list are ignored.
// Reset clears the pipeline valid bits, loads the default configuration and
// rebuilds the matrix. If camera distance plus depth is zero or negative the
// word carries depth_fault with zero coordinates.
`timescale 1ns / 1ps
`default_nettype none

module axis_rotate_project_vertex_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [arpv_pkg::VW-1:0]     i_vertex_x,
    input  logic signed [arpv_pkg::VW-1:0]     i_vertex_y,
    input  logic signed [arpv_pkg::VW-1:0]     i_vertex_z,
    input  logic                               i_last_vertex,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [arpv_pkg::SW-1:0]     o_screen_x,
    output logic signed [arpv_pkg::SW-1:0]     o_screen_y,
    output logic                               o_depth_fault,
    output logic                               o_last_out,
    input  logic                               i_cfg_we,
    input  logic [arpv_pkg::CFG_IDXW-1:0]      i_cfg_index,
    input  logic [arpv_pkg::CFG_DW-1:0]        i_cfg_data
);
    import arpv_pkg::*;

    typedef struct packed {
        logic valid;
        logic last;
        logic fault;
        logic neg_x;
        logic neg_y;
    } t_side;

    localparam int ST_FAULT  = 4;
    localparam int ST_DIV_IN = 6;
    localparam int SIDE_N    = ST_DIV_IN + DIV_LAT + 1;
    localparam int PLW  = VW + LOW + 1;
    localparam int PHW  = VW + HIW;
    localparam int PRW  = VW + MW + 1;
    localparam int SUMW = PRW + 2;
    localparam int PFW  = HALFW + FOVW;
    localparam int NUMW = CW + FOVW;
    localparam int QSW  = QBITS + 2;
    localparam logic signed [SUMW-1:0] HALF_S = SUMW'(ONE_FX / 2);
    localparam logic signed [SW-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0] SAT_MIN = -16'sh8000;

    // configuration registers
    logic [ANGW-1:0]       r_angle;
    logic signed [AXW-1:0] r_ax, r_ay, r_az;
    logic [FOVW-1:0]       r_fov;
    logic [CAMW-1:0]       r_camd;
    logic [VOFFW-1:0]      r_voff;

    t_rot_cfg w_rot_cfg;
    t_mat     w_mat;
    logic     w_busy;
    logic     w_en;

    // pipeline registers
    t_side r_side [SIDE_N];
    logic signed [VW-1:0]  r_s0_v  [3];
    logic signed [PLW-1:0] r_s1_pl [MAT_N];
    logic signed [PHW-1:0] r_s1_ph [MAT_N];
    logic signed [PRW-1:0] r_s2_pr [MAT_N];
    logic signed [CW-1:0]  r_s3_c  [3];
    logic [CW-1:0]   r_s4_ax, r_s4_ay;
    logic [DENW-1:0] r_s4_den, r_s5_den, r_s6_den;
    logic [PFW-1:0]  r_s5_xl, r_s5_xh, r_s5_yl, r_s5_yh;
    logic [NW-1:0]   r_s6_nx, r_s6_ny;

    logic                  r_out_valid;
    logic signed [SW-1:0]  r_sx, r_sy;
    logic                  r_fault, r_last;

    logic signed [PLW-1:0] n_pl [MAT_N];
    logic signed [PHW-1:0] n_ph [MAT_N];
    logic signed [PRW-1:0] n_pr [MAT_N];
    logic signed [SUMW-1:0] n_sum [3];
    logic signed [CW:0]    n_den;
    logic                  n_fault;
    t_side                 n_side0;

    logic [QBITS-1:0]      w_qx, w_qy;
    logic                  w_ovx, w_ovy;
    logic signed [QSW-1:0] w_vx, w_vy, w_px, w_py;

    // saturate a projected coordinate to 16 bits
    function automatic logic signed [SW-1:0] f_sat(input logic signed [QSW-1:0] v,
                                                   input logic ovf, input logic neg);
        logic signed [SW-1:0] res;
        if (ovf) res = neg ? SAT_MIN : SAT_MAX;
        else if (v > QSW'(SAT_MAX)) res = SAT_MAX;
        else if (v < QSW'(SAT_MIN)) res = SAT_MIN;
        else res = SW'(v);
        return res;
    endfunction

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_ax    <= RST_AXIS_X;
            r_ay    <= RST_AXIS_Y;
            r_az    <= RST_AXIS_Z;
            r_fov   <= RST_FOCAL;
            r_camd  <= RST_CAMD;
            r_voff  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ANGLE:   r_angle <= i_cfg_data[ANGW-1:0];
                CFG_AXIS_X:  r_ax    <= $signed(i_cfg_data[AXW-1:0]);
                CFG_AXIS_Y:  r_ay    <= $signed(i_cfg_data[AXW-1:0]);
                CFG_AXIS_Z:  r_az    <= $signed(i_cfg_data[AXW-1:0]);
                CFG_FOCAL:   r_fov   <= i_cfg_data[FOVW-1:0];
                CFG_CAMDIST: r_camd  <= i_cfg_data[CAMW-1:0];
                CFG_VOFF:    r_voff  <= i_cfg_data[VOFFW-1:0];
                default: ;
            endcase
        end
    end

    assign w_rot_cfg = '{angle: r_angle, ax: r_ax, ay: r_ay, az: r_az};

    arpv_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_cfg   (w_rot_cfg),
        .o_mat   (w_mat),
        .o_busy  (w_busy)
    );

    // pipeline advance and input handshake
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en && !w_busy;
    assign n_side0 = '{valid: i_valid && o_ready, last: i_last_vertex,
                       fault: 1'b0, neg_x: 1'b0, neg_y: 1'b0};

    // stage 1: split matrix entries into low and high halves
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_pl[r*3+c] = r_s0_v[r] * $signed({1'b0, w_mat[r*3+c][LOW-1:0]});
                n_ph[r*3+c] = r_s0_v[r] * $signed(w_mat[r*3+c][MW-1:LOW]);
            end
        end
    end

    // stage 2 and 3: full products, column sums with rounding
    always_comb begin
        for (int j = 0; j < MAT_N; j++) begin
            n_pr[j] = (PRW'(r_s1_ph[j]) <<< LOW) + PRW'(r_s1_pl[j]);
        end
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = SUMW'(r_s2_pr[c]) + SUMW'(r_s2_pr[3+c]) + SUMW'(r_s2_pr[6+c])
                     + HALF_S;
        end
    end

    // stage 4: projection denominator and fault
    always_comb begin
        n_den   = (CW+1)'($signed({1'b0, r_camd})) + (CW+1)'(r_s3_c[2]);
        n_fault = n_den[CW] || (n_den == '0);
    end

    // final stage: sign, screen offsets
    always_comb begin
        w_vx = r_side[SIDE_N-1].neg_x ? -QSW'(w_qx) : QSW'(w_qx);
        w_vy = r_side[SIDE_N-1].neg_y ? -QSW'(w_qy) : QSW'(w_qy);
        w_px = w_vx + QSW'(CENTER_X);
        w_py = w_vy + QSW'(CENTER_Y) + QSW'(r_voff);
    end

    // transform datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_v[0] <= i_vertex_x;
            r_s0_v[1] <= i_vertex_y;
            r_s0_v[2] <= i_vertex_z;
            for (int j = 0; j < MAT_N; j++) begin
                r_s1_pl[j] <= n_pl[j];
                r_s1_ph[j] <= n_ph[j];
                r_s2_pr[j] <= n_pr[j];
            end
            for (int c = 0; c < 3; c++) begin
                r_s3_c[c] <= CW'(n_sum[c] >>> FRAC);
            end
            r_s4_ax  <= r_s3_c[0][CW-1] ? CW'(-r_s3_c[0]) : CW'(r_s3_c[0]);
            r_s4_ay  <= r_s3_c[1][CW-1] ? CW'(-r_s3_c[1]) : CW'(r_s3_c[1]);
            r_s4_den <= n_den[CW-1:0];
            r_s5_xl  <= r_s4_ax[HALFW-1:0] * r_fov;
            r_s5_xh  <= r_s4_ax[CW-1:HALFW] * r_fov;
            r_s5_yl  <= r_s4_ay[HALFW-1:0] * r_fov;
            r_s5_yh  <= r_s4_ay[CW-1:HALFW] * r_fov;
            r_s5_den <= r_s4_den;
            r_s6_nx  <= NW'(((NUMW'(r_s5_xh) << HALFW) + NUMW'(r_s5_xl)) >> FRAC);
            r_s6_ny  <= NW'(((NUMW'(r_s5_yh) << HALFW) + NUMW'(r_s5_yl)) >> FRAC);
            r_s6_den <= r_s5_den;
        end
    end

    arpv_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s6_nx),
        .i_den (r_s6_den),
        .o_quo (w_qx),
        .o_ovf (w_ovx)
    );

    arpv_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s6_ny),
        .i_den (r_s6_den),
        .o_quo (w_qy),
        .o_ovf (w_ovy)
    );

    // valid, last and sign bits travel beside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_N; k++) begin
                r_side[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < SIDE_N; k++) begin
                if (k == ST_FAULT) begin
                    // depth fault and signs join at the denominator stage
                    r_side[k] <= '{valid: r_side[k-1].valid, last: r_side[k-1].last,
                                   fault: n_fault, neg_x: r_s3_c[0][CW-1],
                                   neg_y: r_s3_c[1][CW-1]};
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
            r_out_valid <= r_side[SIDE_N-1].valid;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fault <= r_side[SIDE_N-1].fault;
            r_last  <= r_side[SIDE_N-1].last;
            if (r_side[SIDE_N-1].fault) begin
                r_sx <= '0;
                r_sy <= '0;
            end else begin
                r_sx <= f_sat(w_px, w_ovx, r_side[SIDE_N-1].neg_x);
                r_sy <= f_sat(w_py, w_ovy, r_side[SIDE_N-1].neg_y);
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_screen_x    = r_sx;
    assign o_screen_y    = r_sy;
    assign o_depth_fault = r_fault;
    assign o_last_out    = r_last;

    // a faulted word carries zero coordinates
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_depth_fault) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("faulted word with nonzero coordinates");

    // a configuration write blocks input during the matrix rebuild
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input accepted during matrix rebuild");

    // an accepted word enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_side[0].valid)
        else $error("accepted word lost at pipeline entry");

    // a stall freezes the last side stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_side[SIDE_N-1]))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire
